// File: rtl/swst_pkg.sv
`default_nettype none

package swst_pkg;

    localparam int WINDOW_LENGTH_DEF = 32;
    localparam int SAMPLE_BITS_DEF   = 16;

    // fixed field widths of the result
    localparam int OUT_BITS   = 16;
    localparam int SUM_BITS   = 21;
    localparam int SQSUM_BITS = 36;
    localparam int VAR_BITS   = 31;
    localparam int AREA_BITS  = 21;
    localparam int LEN_BITS   = 5;

    // dividend width of the shared divider: holds sum*sum
    localparam int DIV_BITS = 2 * SUM_BITS;

endpackage

`default_nettype wire

// File: rtl/swst_ram.sv
`default_nettype none

module swst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// File: rtl/sliding_window_statistics_top.sv
// when WINDOW_LENGTH is a power of two, the time from request to result is set by the min/max
// scan and the peak walk, which run side by side on two read ports; otherwise the walk waits
// for the mean, and each division takes 3 digits of a reciprocal multiply and a remainder step
// a new request is taken once the last result is in the output register, also while it waits
// reset: asynchronous, active low; a clearing pass then writes WINDOW_LENGTH zero entries,
// one per cycle, before the first request is taken
`default_nettype none

module sliding_window_statistics_top #(
    parameter int WINDOW_LENGTH = swst_pkg::WINDOW_LENGTH_DEF,
    parameter int SAMPLE_BITS   = swst_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      in_valid,
    output logic                                           in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]             sample,
    output logic                                           out_valid,
    input  wire logic                                      out_ready,
    output logic signed [swst_pkg::OUT_BITS-1:0]           window_min,
    output logic signed [swst_pkg::OUT_BITS-1:0]           window_max,
    output logic signed [swst_pkg::SUM_BITS-1:0]           window_sum,
    output logic        [swst_pkg::SQSUM_BITS-1:0]         window_sqsum,
    output logic signed [swst_pkg::OUT_BITS-1:0]           window_mean,
    output logic        [swst_pkg::VAR_BITS-1:0]           window_variance,
    output logic                                           peak_sign,
    output logic        [swst_pkg::OUT_BITS-1:0]           peak_amplitude,
    output logic        [swst_pkg::AREA_BITS-1:0]          peak_area,
    output logic        [swst_pkg::LEN_BITS-1:0]           peak_length
);

    localparam int AW   = $clog2(WINDOW_LENGTH);
    localparam int NW   = $clog2(WINDOW_LENGTH + 1);
    localparam int DW   = ((SAMPLE_BITS > swst_pkg::SUM_BITS) ? SAMPLE_BITS
                                                              : swst_pkg::SUM_BITS) + 1;
    localparam int SQW  = (2 * SAMPLE_BITS > swst_pkg::SQSUM_BITS) ? 2 * SAMPLE_BITS
                                                                   : swst_pkg::SQSUM_BITS;
    localparam int SB   = swst_pkg::SUM_BITS;
    localparam int QB   = swst_pkg::SQSUM_BITS;
    localparam int DB   = swst_pkg::DIV_BITS;
    localparam bit POW2 = (WINDOW_LENGTH & (WINDOW_LENGTH - 1)) == 0;

    // long division in digits: each partial dividend is below WINDOW_LENGTH << DIG
    localparam int DIG  = 14;
    localparam int NDIG = DB / DIG;
    localparam int VW   = AW + DIG;
    localparam int RS   = VW + AW;
    localparam int CW   = $clog2(2 * NDIG + 1);
    localparam logic [VW:0] RECIP =
        (VW + 1)'(((longint'(1) << RS) + longint'(WINDOW_LENGTH) - 1) / longint'(WINDOW_LENGTH));

    localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_LENGTH - 1);

    localparam logic [2:0] M_CLEAR = 3'd0;
    localparam logic [2:0] M_IDLE  = 3'd1;
    localparam logic [2:0] M_OLD   = 3'd2;
    localparam logic [2:0] M_UPD   = 3'd3;
    localparam logic [2:0] M_RUN   = 3'd4;

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MEAN = 3'd1;
    localparam logic [2:0] A_SQ   = 3'd2;
    localparam logic [2:0] A_PROD = 3'd3;
    localparam logic [2:0] A_Q1   = 3'd4;
    localparam logic [2:0] A_SUB  = 3'd5;
    localparam logic [2:0] A_Q2   = 3'd6;
    localparam logic [2:0] A_FIN  = 3'd7;

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST_ADDR : a - 1'b1;
    endfunction

    function automatic logic [QB-1:0] square(input logic signed [SAMPLE_BITS-1:0] x);
        logic [SAMPLE_BITS-1:0] m;
        logic [SQW-1:0]         p;
        m = x[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x) : SAMPLE_BITS'(x);
        p = SQW'(m) * SQW'(m);
        return p[QB-1:0];
    endfunction

    // sequencer state
    logic [2:0]    m_state_reg;
    logic [2:0]    a_state_reg;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] sc_addr_reg;
    logic [AW-1:0] wk_addr_reg;
    logic [NW-1:0] sc_issue_reg;
    logic [NW-1:0] sc_ret_reg;
    logic          sc_rv_reg;
    logic          sc_done_reg;
    logic [NW-1:0] wk_issue_reg;
    logic          wk_rv_reg;
    logic          wk_done_reg;
    logic [NW-1:0] len_reg;
    logic          out_valid_reg;

    // running state and per-request data
    logic signed [SB-1:0]          sum_reg;
    logic        [QB-1:0]          sqsum_reg;
    logic signed [SAMPLE_BITS-1:0] s_reg;
    logic        [QB-1:0]          newsq_reg;
    logic        [QB-1:0]          oldsq_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg;
    logic signed [SAMPLE_BITS-1:0] max_reg;
    logic signed [SB-1:0]          mean_reg;
    logic        [DB-1:0]          prod_reg;
    logic        [DB-1:0]          diff_reg;
    logic        [swst_pkg::VAR_BITS-1:0]  var_reg;
    logic                          sgn_reg;
    logic        [DW-1:0]          amp_reg;
    logic        [swst_pkg::AREA_BITS-1:0] area_reg;

    // divider
    logic           div_busy_reg;
    logic [CW-1:0]  div_cnt_reg;
    logic [DB-1:0]  div_q_reg;
    logic [AW-1:0]  div_rem_reg;
    logic [DIG-1:0] div_digit_reg;
    logic           div_start;
    logic           div_done;
    logic [DB-1:0]  div_dividend;
    logic [VW-1:0]  div_v;
    logic [2*VW-1:0] div_prod;
    logic [VW-1:0]  div_back;

    // output register
    logic signed [swst_pkg::OUT_BITS-1:0]  min_o_reg;
    logic signed [swst_pkg::OUT_BITS-1:0]  max_o_reg;
    logic signed [SB-1:0]                  sum_o_reg;
    logic        [QB-1:0]                  sqsum_o_reg;
    logic signed [swst_pkg::OUT_BITS-1:0]  mean_o_reg;
    logic        [swst_pkg::VAR_BITS-1:0]  var_o_reg;
    logic                                  sign_o_reg;
    logic        [swst_pkg::OUT_BITS-1:0]  amp_o_reg;
    logic        [swst_pkg::AREA_BITS-1:0] area_o_reg;
    logic        [swst_pkg::LEN_BITS-1:0]  len_o_reg;

    // ram ports
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr_a;
    logic [SAMPLE_BITS-1:0] ram_rdata_a;
    logic [SAMPLE_BITS-1:0] ram_rdata_b;

    logic signed [SAMPLE_BITS-1:0] rd_a;
    logic signed [SAMPLE_BITS-1:0] rd_b;
    logic                          accept;
    logic                          arith_go;
    logic                          mean_ok;
    logic                          sc_issue;
    logic                          wk_issue;
    logic signed [DW-1:0]          wk_dev;
    logic                          wk_neg;
    logic        [DW-1:0]          wk_abs;
    logic                          wk_take;
    logic                          wk_stop;
    logic                          out_load;
    logic        [SB-1:0]          sum_mag;
    logic        [DB-1:0]          diff_mag;

    swst_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_LENGTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (wk_addr_reg),
        .rdata_b (ram_rdata_b)
    );

    assign rd_a = $signed(ram_rdata_a);
    assign rd_b = $signed(ram_rdata_b);

    assign in_ready = (m_state_reg == M_IDLE);
    assign accept   = in_valid && in_ready;
    assign arith_go = (m_state_reg == M_UPD);
    assign mean_ok  = (a_state_reg != A_IDLE) && (a_state_reg != A_MEAN);

    // the write lands on the oldest slot, which becomes the newest
    assign ram_we      = (m_state_reg == M_CLEAR) || (m_state_reg == M_OLD);
    assign ram_waddr   = (m_state_reg == M_CLEAR) ? sc_addr_reg : head_reg;
    assign ram_wdata   = (m_state_reg == M_CLEAR) ? '0 : s_reg;
    assign ram_raddr_a = (m_state_reg == M_IDLE) ? head_reg : sc_addr_reg;

    assign sc_issue = (m_state_reg == M_RUN) && (sc_issue_reg != NW'(WINDOW_LENGTH));
    assign wk_issue = (m_state_reg == M_RUN) && mean_ok && !wk_done_reg
                      && (wk_issue_reg != NW'(WINDOW_LENGTH - 1));

    // peak walk, newest entry first
    assign wk_dev  = DW'(rd_b) - DW'(mean_reg);
    assign wk_neg  = wk_dev[DW-1];
    assign wk_abs  = wk_neg ? DW'(-wk_dev) : DW'(wk_dev);
    assign wk_take = wk_rv_reg && !wk_done_reg && ((len_reg == '0) || (!wk_neg == sgn_reg));
    assign wk_stop = wk_rv_reg && !wk_done_reg && !wk_take;

    assign out_load = (m_state_reg == M_RUN) && sc_done_reg && wk_done_reg
                      && (a_state_reg == A_FIN) && (!out_valid_reg || out_ready);

    assign sum_mag  = sum_reg[SB-1] ? SB'(-sum_reg) : SB'(sum_reg);
    assign diff_mag = diff_reg[DB-1] ? DB'(-diff_reg) : diff_reg;

    // divide by WINDOW_LENGTH: a shift for a power of two, else long division by digits,
    // each digit by a registered reciprocal multiply, then the remainder
    assign div_start = ((a_state_reg == A_IDLE) && arith_go)
                       || (a_state_reg == A_PROD) || (a_state_reg == A_SUB);
    assign div_done  = div_busy_reg && (div_cnt_reg == '0);
    assign div_v     = {div_rem_reg, div_q_reg[DB-1 -: DIG]};
    assign div_prod  = (2 * VW)'(div_v) * (2 * VW)'(RECIP);
    assign div_back  = div_v - VW'(div_digit_reg) * VW'(WINDOW_LENGTH);

    always_comb
    begin
        case (a_state_reg)
            A_PROD:  div_dividend = prod_reg;
            A_SUB:   div_dividend = diff_mag;
            default: div_dividend = DB'(sum_mag);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= POW2 ? '0 : CW'(2 * NDIG);
        end
        else if (div_busy_reg)
        begin
            if (div_cnt_reg == '0)
            begin
                div_busy_reg <= 1'b0;
            end
            else
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_rem_reg <= '0;
            if (POW2)
            begin
                div_q_reg <= div_dividend >> AW;
            end
            else
            begin
                div_q_reg <= div_dividend;
            end
        end
        else if (div_busy_reg && (div_cnt_reg != '0))
        begin
            if (!div_cnt_reg[0])
            begin
                div_digit_reg <= div_prod[RS +: DIG];
            end
            else
            begin
                div_q_reg   <= {div_q_reg[DB-DIG-1:0], div_digit_reg};
                div_rem_reg <= div_back[AW-1:0];
            end
        end
    end

    // mean, then variance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_state_reg <= A_IDLE;
        end
        else
        begin
            case (a_state_reg)
                A_IDLE: if (arith_go) a_state_reg <= A_MEAN;
                A_MEAN: if (div_done) a_state_reg <= A_SQ;
                A_SQ:   a_state_reg <= A_PROD;
                A_PROD: a_state_reg <= A_Q1;
                A_Q1:   if (div_done) a_state_reg <= A_SUB;
                A_SUB:  a_state_reg <= A_Q2;
                A_Q2:   if (div_done) a_state_reg <= A_FIN;
                A_FIN:  if (out_load) a_state_reg <= A_IDLE;
                default: a_state_reg <= A_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((a_state_reg == A_MEAN) && div_done)
        begin
            mean_reg <= sum_reg[SB-1] ? -SB'(div_q_reg) : SB'(div_q_reg);
        end
        if (a_state_reg == A_SQ)
        begin
            prod_reg <= DB'(sum_reg * sum_reg);
        end
        if ((a_state_reg == A_Q1) && div_done)
        begin
            diff_reg <= DB'(sqsum_reg) - div_q_reg;
        end
        if ((a_state_reg == A_Q2) && div_done)
        begin
            var_reg <= diff_reg[DB-1] ? swst_pkg::VAR_BITS'(-div_q_reg)
                                      : swst_pkg::VAR_BITS'(div_q_reg);
        end
    end

    // window sequencer: clear, read oldest, replace, scan and walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_state_reg   <= M_CLEAR;
            head_reg      <= '0;
            sc_addr_reg   <= '0;
            wk_addr_reg   <= '0;
            sc_issue_reg  <= '0;
            sc_ret_reg    <= '0;
            sc_rv_reg     <= 1'b0;
            sc_done_reg   <= 1'b0;
            wk_issue_reg  <= '0;
            wk_rv_reg     <= 1'b0;
            wk_done_reg   <= 1'b0;
            len_reg       <= '0;
            sum_reg       <= '0;
            sqsum_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sc_rv_reg <= sc_issue;
            wk_rv_reg <= wk_issue;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (m_state_reg)
                M_CLEAR:
                begin
                    sc_addr_reg <= addr_inc(sc_addr_reg);
                    if (sc_addr_reg == LAST_ADDR)
                    begin
                        m_state_reg <= M_IDLE;
                    end
                end
                M_IDLE:
                begin
                    if (accept)
                    begin
                        m_state_reg <= M_OLD;
                    end
                end
                M_OLD:
                begin
                    sum_reg      <= sum_reg - SB'(rd_a) + SB'(s_reg);
                    head_reg     <= addr_inc(head_reg);
                    sc_addr_reg  <= addr_inc(head_reg);
                    wk_addr_reg  <= head_reg;
                    sc_issue_reg <= '0;
                    sc_ret_reg   <= '0;
                    sc_done_reg  <= 1'b0;
                    wk_issue_reg <= '0;
                    wk_done_reg  <= 1'b0;
                    len_reg      <= '0;
                    m_state_reg  <= M_UPD;
                end
                M_UPD:
                begin
                    sqsum_reg   <= sqsum_reg - oldsq_reg + newsq_reg;
                    m_state_reg <= M_RUN;
                end
                M_RUN:
                begin
                    if (sc_issue)
                    begin
                        sc_addr_reg  <= addr_inc(sc_addr_reg);
                        sc_issue_reg <= sc_issue_reg + 1'b1;
                    end
                    if (sc_rv_reg)
                    begin
                        sc_ret_reg <= sc_ret_reg + 1'b1;
                        if (sc_ret_reg == NW'(WINDOW_LENGTH - 1))
                        begin
                            sc_done_reg <= 1'b1;
                        end
                    end
                    if (wk_issue)
                    begin
                        wk_addr_reg  <= addr_dec(wk_addr_reg);
                        wk_issue_reg <= wk_issue_reg + 1'b1;
                    end
                    // the walk stops short of the oldest entry
                    if (wk_take)
                    begin
                        len_reg <= len_reg + 1'b1;
                        if (len_reg == NW'(WINDOW_LENGTH - 2))
                        begin
                            wk_done_reg <= 1'b1;
                        end
                    end
                    else if (wk_stop)
                    begin
                        wk_done_reg <= 1'b1;
                    end
                    if (out_load)
                    begin
                        m_state_reg <= M_IDLE;
                    end
                end
                default: m_state_reg <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_reg     <= sample;
            newsq_reg <= square(sample);
        end
        if (m_state_reg == M_OLD)
        begin
            oldsq_reg <= square(rd_a);
            amp_reg   <= '0;
            area_reg  <= '0;
        end
        if (sc_rv_reg)
        begin
            if (sc_ret_reg == '0)
            begin
                min_reg <= rd_a;
                max_reg <= rd_a;
            end
            else
            begin
                if (rd_a < min_reg)
                begin
                    min_reg <= rd_a;
                end
                if (rd_a > max_reg)
                begin
                    max_reg <= rd_a;
                end
            end
        end
        if (wk_take)
        begin
            if (len_reg == '0)
            begin
                sgn_reg <= !wk_neg;
            end
            area_reg <= area_reg + wk_abs[swst_pkg::AREA_BITS-1:0];
            if (wk_abs > amp_reg)
            begin
                amp_reg <= wk_abs;
            end
        end
        if (out_load)
        begin
            min_o_reg   <= swst_pkg::OUT_BITS'(min_reg);
            max_o_reg   <= swst_pkg::OUT_BITS'(max_reg);
            sum_o_reg   <= sum_reg;
            sqsum_o_reg <= sqsum_reg;
            mean_o_reg  <= mean_reg[swst_pkg::OUT_BITS-1:0];
            var_o_reg   <= var_reg;
            sign_o_reg  <= sgn_reg;
            amp_o_reg   <= amp_reg[swst_pkg::OUT_BITS-1:0];
            area_o_reg  <= area_reg;
            len_o_reg   <= swst_pkg::LEN_BITS'(len_reg);
        end
    end

    assign out_valid       = out_valid_reg;
    assign window_min      = min_o_reg;
    assign window_max      = max_o_reg;
    assign window_sum      = sum_o_reg;
    assign window_sqsum    = sqsum_o_reg;
    assign window_mean     = mean_o_reg;
    assign window_variance = var_o_reg;
    assign peak_sign       = sign_o_reg;
    assign peak_amplitude  = amp_o_reg;
    assign peak_area       = area_o_reg;
    assign peak_length     = len_o_reg;

`ifndef SYNTHESIS
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("request taken while another is in progress");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy_reg |-> (a_state_reg == A_MEAN || a_state_reg == A_Q1
                          || a_state_reg == A_Q2))
        else $error("divider busy outside a wait state");

    a_walk_len: assert property (@(posedge clk) disable iff (!rst_n)
        wk_done_reg |-> (len_reg != '0 && len_reg <= NW'(WINDOW_LENGTH - 1)))
        else $error("peak length out of range");

    a_result_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(sc_done_reg && wk_done_reg && a_state_reg == A_FIN))
        else $error("result loaded before scan, walk and variance finished");
`endif

endmodule

`default_nettype wire

// File: dv/sliding_window_statistics_checker.sv
`default_nettype none

module sliding_window_statistics_checker (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      in_valid,
    input  wire logic                                      in_ready,
    input  wire logic signed [swst_pkg::SAMPLE_BITS_DEF-1:0] sample,
    input  wire logic                                      out_valid,
    input  wire logic                                      out_ready,
    input  wire logic signed [swst_pkg::OUT_BITS-1:0]      window_min,
    input  wire logic signed [swst_pkg::OUT_BITS-1:0]      window_max,
    input  wire logic signed [swst_pkg::SUM_BITS-1:0]      window_sum,
    input  wire logic        [swst_pkg::SQSUM_BITS-1:0]    window_sqsum,
    input  wire logic signed [swst_pkg::OUT_BITS-1:0]      window_mean,
    input  wire logic        [swst_pkg::VAR_BITS-1:0]      window_variance,
    input  wire logic                                      peak_sign,
    input  wire logic        [swst_pkg::OUT_BITS-1:0]      peak_amplitude,
    input  wire logic        [swst_pkg::AREA_BITS-1:0]     peak_area,
    input  wire logic        [swst_pkg::LEN_BITS-1:0]      peak_length,
    output int                                             fail_count,
    output int                                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import swst_pkg::*;

    localparam int WL = WINDOW_LENGTH_DEF;
    localparam int SB = SAMPLE_BITS_DEF;
    localparam int MAX_PRINTED = 200;

    typedef struct packed {
        logic signed [OUT_BITS-1:0]   lo;
        logic signed [OUT_BITS-1:0]   hi;
        logic signed [SUM_BITS-1:0]   sum;
        logic        [SQSUM_BITS-1:0] sqsum;
        logic signed [OUT_BITS-1:0]   mean;
        logic        [VAR_BITS-1:0]   variance;
        logic                         sign;
        logic        [OUT_BITS-1:0]   amplitude;
        logic        [AREA_BITS-1:0]  area;
        logic        [LEN_BITS-1:0]   length;
    } window_stats_t;

    logic signed [SB-1:0]         window_hist [WL];
    logic signed [SUM_BITS-1:0]   acc_sum;
    logic        [SQSUM_BITS-1:0] acc_sqsum;
    window_stats_t                expected_stats [$];
    window_stats_t                seen, want;

    initial begin
        fail_count = 0;
        pending = 0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint exp_v);
        if (fail_count < MAX_PRINTED)
            $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, exp_v);
        fail_count++;
    endtask

    // shift in one sample and work out every field of the result it causes
    task automatic advance_window(input logic signed [SB-1:0] s, output window_stats_t st);
        longint old_v, olds, news, tmp, lo, hi, mean, var_v, dev, amp, area, sum_l;
        int i;
        bit sgn;
        old_v = window_hist[0];
        olds = (old_v < 0) ? -old_v : old_v;
        news = (s < 0) ? -longint'(s) : longint'(s);

        tmp = longint'(acc_sum) - old_v + longint'(s);
        acc_sum = tmp[SUM_BITS-1:0];
        tmp = longint'(acc_sqsum) - olds * olds + news * news;
        acc_sqsum = tmp[SQSUM_BITS-1:0];

        for (int k = 0; k < WL - 1; k++)
            window_hist[k] = window_hist[k + 1];
        window_hist[WL-1] = s;

        lo = window_hist[0];
        hi = window_hist[0];
        for (int k = 1; k < WL; k++)
        begin
            if (window_hist[k] < lo) lo = window_hist[k];
            if (window_hist[k] > hi) hi = window_hist[k];
        end

        sum_l = acc_sum;
        mean = sum_l / WL;
        var_v = (longint'(acc_sqsum) - (sum_l * sum_l) / WL) / WL;

        // walk back over the newest same-sign run, never touching the oldest entry
        i = WL - 1;
        sgn = (longint'(window_hist[i]) - mean) >= 0;
        amp = 0;
        area = 0;
        do
        begin
            dev = longint'(window_hist[i]) - mean;
            if (dev < 0) dev = -dev;
            area += dev;
            if (dev > amp) amp = dev;
            i--;
        end
        while (i > 0 && (((longint'(window_hist[i]) - mean) >= 0) == sgn));

        st.lo        = lo[OUT_BITS-1:0];
        st.hi        = hi[OUT_BITS-1:0];
        st.sum       = acc_sum;
        st.sqsum     = acc_sqsum;
        st.mean      = mean[OUT_BITS-1:0];
        st.variance  = var_v[VAR_BITS-1:0];
        st.sign      = sgn;
        st.amplitude = amp[OUT_BITS-1:0];
        st.area      = area[AREA_BITS-1:0];
        tmp = WL - 1 - i;
        st.length    = tmp[LEN_BITS-1:0];
    endtask

    task automatic compare_stats(input window_stats_t g, input window_stats_t e);
        if (g.lo !== e.lo) report_mismatch("window_min", g.lo, e.lo);
        if (g.hi !== e.hi) report_mismatch("window_max", g.hi, e.hi);
        if (g.sum !== e.sum) report_mismatch("window_sum", g.sum, e.sum);
        if (g.sqsum !== e.sqsum) report_mismatch("window_sqsum", g.sqsum, e.sqsum);
        if (g.mean !== e.mean) report_mismatch("window_mean", g.mean, e.mean);
        if (g.variance !== e.variance)
            report_mismatch("window_variance", g.variance, e.variance);
        if (g.sign !== e.sign) report_mismatch("peak_sign", g.sign, e.sign);
        if (g.amplitude !== e.amplitude)
            report_mismatch("peak_amplitude", g.amplitude, e.amplitude);
        if (g.area !== e.area) report_mismatch("peak_area", g.area, e.area);
        if (g.length !== e.length) report_mismatch("peak_length", g.length, e.length);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WL; k++)
                window_hist[k] = '0;
            acc_sum = '0;
            acc_sqsum = '0;
            expected_stats.delete();
            pending <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                advance_window(sample, want);
                expected_stats.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                seen.lo        = window_min;
                seen.hi        = window_max;
                seen.sum       = window_sum;
                seen.sqsum     = window_sqsum;
                seen.mean      = window_mean;
                seen.variance  = window_variance;
                seen.sign      = peak_sign;
                seen.amplitude = peak_amplitude;
                seen.area      = peak_area;
                seen.length    = peak_length;
                if (expected_stats.size() == 0)
                    report_mismatch("result with no request waiting", 0, 0);
                else
                    compare_stats(seen, expected_stats.pop_front());
            end
            pending <= expected_stats.size();
        end
    end

endmodule

`default_nettype wire

// File: dv/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import swst_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int N_RANDOM = 1700;
    localparam int LONG_HOLD = 1000;
    localparam int MAX_GAP = 150;
    localparam int TAIL_WAIT = 150;
    // per item: slowest block latency, longest sender gap, longest short receiver stall
    localparam longint CYCLE_LIMIT =
        4 * ((N_RANDOM + 100) * (3 * 42 + 10 + MAX_GAP + 60) + 40 * LONG_HOLD + 1000);

    typedef enum int {
        BURST_UNIFORM,
        BURST_SMALL,
        BURST_EXTREME,
        BURST_CONSTANT,
        BURST_RAMP,
        BURST_SQUARE
    } burst_kind_e;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic signed [SB-1:0]           sample = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [OUT_BITS-1:0]     window_min;
    logic signed [OUT_BITS-1:0]     window_max;
    logic signed [SUM_BITS-1:0]     window_sum;
    logic        [SQSUM_BITS-1:0]   window_sqsum;
    logic signed [OUT_BITS-1:0]     window_mean;
    logic        [VAR_BITS-1:0]     window_variance;
    logic                           peak_sign;
    logic        [OUT_BITS-1:0]     peak_amplitude;
    logic        [AREA_BITS-1:0]    peak_area;
    logic        [LEN_BITS-1:0]     peak_length;
    int                             fail_count;
    int                             pending;
    longint                         cycle_count = 0;

    always #10ns clk = ~clk;

    sliding_window_statistics_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .window_min      (window_min),
        .window_max      (window_max),
        .window_sum      (window_sum),
        .window_sqsum    (window_sqsum),
        .window_mean     (window_mean),
        .window_variance (window_variance),
        .peak_sign       (peak_sign),
        .peak_amplitude  (peak_amplitude),
        .peak_area       (peak_area),
        .peak_length     (peak_length)
    );

    sliding_window_statistics_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .window_min      (window_min),
        .window_max      (window_max),
        .window_sum      (window_sum),
        .window_sqsum    (window_sqsum),
        .window_mean     (window_mean),
        .window_variance (window_variance),
        .peak_sign       (peak_sign),
        .peak_amplitude  (peak_amplitude),
        .peak_area       (peak_area),
        .peak_length     (peak_length),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 80) return $urandom_range(1, 5);
        if (r < 95) return $urandom_range(6, 45);
        return $urandom_range(50, MAX_GAP);
    endfunction

    function automatic int random_sample();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int extreme_sample();
        case ($urandom_range(0, 3))
            0: return 32767;
            1: return -32768;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    // one request; called at a rising edge, returns at the edge that accepts it
    task automatic send_sample(input int v, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= v[SB-1:0];
        do @(posedge clk); while (!in_ready);
    endtask

    // receiver: random stalls, open stretches, and now and then a long hold
    initial
    begin
        int rounds;
        int n;
        rounds = 0;
        @(posedge clk);
        forever
        begin
            rounds++;
            if (rounds % 200 == 20)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0, 1:
                    begin
                        out_ready <= 1'b1;
                        n = $urandom_range(1, 60);
                    end
                    2:
                    begin
                        out_ready <= 1'b0;
                        n = $urandom_range(1, 4);
                    end
                    default:
                    begin
                        out_ready <= 1'b0;
                        n = $urandom_range(10, 60);
                    end
                endcase
                repeat (n) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int directed [$];
        int sent;
        int len;
        int c;
        int step;
        int v;
        burst_kind_e kind;

        // first sample zero on the cleared window: every deviation zero, longest walk
        directed = '{0, 32767, -32768, 32767, -32768, -1, 1, 0, 21845, -21846,
                     1000, -1000, 2, 32767, 32767, 32767, 32767, 32767, 32767,
                     -5, -5, -5, 7, -32768, 0};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
            send_sample(directed[k], (k % 5 == 4) ? $urandom_range(1, 40) : 0);

        sent = 0;
        while (sent < N_RANDOM)
        begin
            kind = burst_kind_e'($urandom_range(0, 5));
            len = $urandom_range(8, 80);
            step = $urandom_range(1, 20);
            case ($urandom_range(0, 2))
                0: c = extreme_sample();
                default: c = random_sample();
            endcase
            if (kind == BURST_CONSTANT || kind == BURST_EXTREME)
                len = $urandom_range(33, 90);
            for (int k = 0; k < len; k++)
            begin
                case (kind)
                    BURST_UNIFORM:  v = random_sample();
                    BURST_SMALL:    v = int'($urandom_range(0, 15)) - 8;
                    BURST_EXTREME:  v = ($urandom_range(0, 3) == 0) ? extreme_sample() : c;
                    BURST_CONSTANT: v = c;
                    BURST_RAMP:     v = c + step * 97 * k;
                    default:        v = ((k / step) % 2 == 0) ? c : -c;
                endcase
                send_sample(v, pick_gap());
            end
            sent += len;
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/swst_pkg.sv
rtl/swst_ram.sv
rtl/sliding_window_statistics_top.sv
dv/sliding_window_statistics_checker.sv
dv/testbench.sv
